@@ hw/rtl/vac_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vac_pkg
// Types and constants shared by the vector angle cosine block.
// ----------------------------------------------------------------------------
package vac_pkg;

	localparam int DIV_N  = 57;
	localparam int SQRT_N = 29;

	localparam logic signed [31:0] MARKER_FOUR = 32'sd1073741824;

	typedef struct packed {
		logic signed [31:0] apex_x;
		logic signed [31:0] apex_y;
		logic signed [31:0] apex_z;
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] first_z;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
		logic signed [31:0] second_z;
	} item_t;

	typedef struct packed {
		logic signed [31:0] cosine;
		logic               degenerate;
	} result_t;

	typedef struct packed {
		logic neg;
		logic degen;
	} side_t;

endpackage

@@ hw/rtl/vac_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vac_mul
// 66 x 66 unsigned multiplier, two stages: four partial products of the
// 33-bit halves, then their sum.
// ----------------------------------------------------------------------------
module vac_mul (
	input  logic         clk,
	input  logic         en,
	input  logic [65:0]  a,
	input  logic [65:0]  b,
	output logic [131:0] p
);

	logic [65:0]  ll_s1, lh_s1, hl_s1, hh_s1;
	logic [131:0] p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= 66'(a[32:0]) * 66'(b[32:0]);
			lh_s1 <= 66'(a[32:0]) * 66'(b[65:33]);
			hl_s1 <= 66'(a[65:33]) * 66'(b[32:0]);
			hh_s1 <= 66'(a[65:33]) * 66'(b[65:33]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= 132'(ll_s1) + ((132'(lh_s1) + 132'(hl_s1)) << 33) + (132'(hh_s1) << 66);
		end
	end

	assign p = p_s2;

endmodule

@@ hw/rtl/vector_angle_cosine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_angle_cosine
// Cosine of the angle at an apex between two 3D edges, Q16.16 in, Q3.28 out,
// exact and truncated; marker 4.0 with degenerate flag for short edges.
// ----------------------------------------------------------------------------
// channel  dir  handshake                  beat
// item     in   item_valid / item_stall    vac_pkg::item_t
// result   out  result_valid / result_stall vac_pkg::result_t
// cfg      in   cfg_valid / cfg_ready      min_length, 16 bits
//
// One beat per cycle sustained while results are not stalled; stages: 7 of edges,
// squares and products, 57 divider stages, 29 square root stages, output reg.
// Reset clears all valid bits; min_length resets to 1.
// A stalled result parks the next beat in a skid register; item_stall is the
// skid flag, registered, and freezes the pipeline until the skid drains.
// ----------------------------------------------------------------------------
module vector_angle_cosine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  vac_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output vac_pkg::result_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [15:0]       cfg_data
);

	logic [15:0] min_length_q;
	logic        skid_valid_q;
	logic        en;

	assign cfg_ready  = 1'b1;
	assign en         = !skid_valid_q;
	assign item_stall = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			min_length_q <= cfg_data;
		end
	end

	// edges
	logic signed [31:0] ax [3], fx [3], sx [3];
	assign ax[0] = item.apex_x;   assign ax[1] = item.apex_y;   assign ax[2] = item.apex_z;
	assign fx[0] = item.first_x;  assign fx[1] = item.first_y;  assign fx[2] = item.first_z;
	assign sx[0] = item.second_x; assign sx[1] = item.second_y; assign sx[2] = item.second_z;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [32:0] u_s1 [3], w_s1 [3];
	logic [32:0]        mu_s2 [3], mw_s2 [3];
	logic [2:0]         xs_s2, xs_s3;
	logic [65:0]        uu_s3 [3], ww_s3 [3], uw_s3 [3];
	logic [65:0]        l1_s4, l2_s4, pos_s4, neg_s4;
	logic [65:0]        dot_s5, l1_s5, l2_s5;
	vac_pkg::side_t     side_s5, side_s6, side_s7;
	logic [31:0]        lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				u_s1[k]  <= 33'(fx[k]) - 33'(ax[k]);
				w_s1[k]  <= 33'(sx[k]) - 33'(ax[k]);
				mu_s2[k] <= u_s1[k][32] ? 33'(-u_s1[k]) : 33'(u_s1[k]);
				mw_s2[k] <= w_s1[k][32] ? 33'(-w_s1[k]) : 33'(w_s1[k]);
				xs_s2[k] <= u_s1[k][32] ^ w_s1[k][32];
				uu_s3[k] <= 66'(mu_s2[k]) * 66'(mu_s2[k]);
				ww_s3[k] <= 66'(mw_s2[k]) * 66'(mw_s2[k]);
				uw_s3[k] <= 66'(mu_s2[k]) * 66'(mw_s2[k]);
			end
			xs_s3  <= xs_s2;
			l1_s4  <= uu_s3[0] + uu_s3[1] + uu_s3[2];
			l2_s4  <= ww_s3[0] + ww_s3[1] + ww_s3[2];
			pos_s4 <= (xs_s3[0] ? 66'd0 : uw_s3[0]) + (xs_s3[1] ? 66'd0 : uw_s3[1])
				+ (xs_s3[2] ? 66'd0 : uw_s3[2]);
			neg_s4 <= (xs_s3[0] ? uw_s3[0] : 66'd0) + (xs_s3[1] ? uw_s3[1] : 66'd0)
				+ (xs_s3[2] ? uw_s3[2] : 66'd0);
			dot_s5 <= (pos_s4 >= neg_s4) ? pos_s4 - neg_s4 : neg_s4 - pos_s4;
			side_s5.neg   <= pos_s4 < neg_s4;
			side_s5.degen <= (l1_s4 == 66'd0) || (l2_s4 == 66'd0)
				|| (l1_s4 < 66'(lim)) || (l2_s4 < 66'(lim));
			l1_s5   <= l1_s4;
			l2_s5   <= l2_s4;
			side_s6 <= side_s5;
			side_s7 <= side_s6;
		end
	end

	assign lim = 32'(min_length_q) * 32'(min_length_q);

	logic [131:0] dd, pp;

	vac_mul u_mul_dot (.clk(clk), .en(en), .a(dot_s5), .b(dot_s5), .p(dd));
	vac_mul u_mul_len (.clk(clk), .en(en), .a(l1_s5), .b(l2_s5), .p(pp));

	// quotient dot^2 * 2^56 / (l1 * l2), one bit a stage
	logic                        div_v_s    [vac_pkg::DIV_N+1];
	logic [131:0]                div_rem_s  [vac_pkg::DIV_N+1];
	logic [131:0]                div_den_s  [vac_pkg::DIV_N+1];
	logic [vac_pkg::DIV_N-1:0]   div_quo_s  [vac_pkg::DIV_N+1];
	vac_pkg::side_t              div_side_s [vac_pkg::DIV_N+1];

	assign div_v_s[0]    = v_s7;
	assign div_rem_s[0]  = dd;
	assign div_den_s[0]  = pp;
	assign div_quo_s[0]  = '0;
	assign div_side_s[0] = side_s7;

	for (genvar k = 0; k < vac_pkg::DIV_N; k++) begin : g_div
		logic [132:0] rr, diff;
		logic         take;
		assign rr   = (k == 0) ? {1'b0, div_rem_s[k]} : {div_rem_s[k], 1'b0};
		assign take = rr >= {1'b0, div_den_s[k]};
		assign diff = rr - {1'b0, div_den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[k+1] <= 1'b0;
			end else if (en) begin
				div_v_s[k+1] <= div_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_rem_s[k+1]  <= take ? diff[131:0] : rr[131:0];
				div_quo_s[k+1]  <= {div_quo_s[k][vac_pkg::DIV_N-2:0], take};
				div_den_s[k+1]  <= div_den_s[k];
				div_side_s[k+1] <= div_side_s[k];
			end
		end
	end

	// integer square root of the quotient, one root bit a stage
	logic                        sq_v_s    [vac_pkg::SQRT_N+1];
	logic [57:0]                 sq_rem_s  [vac_pkg::SQRT_N+1];
	logic [vac_pkg::SQRT_N-1:0]  sq_root_s [vac_pkg::SQRT_N+1];
	vac_pkg::side_t              sq_side_s [vac_pkg::SQRT_N+1];

	assign sq_v_s[0]    = div_v_s[vac_pkg::DIV_N];
	assign sq_rem_s[0]  = 58'(div_quo_s[vac_pkg::DIV_N]);
	assign sq_root_s[0] = '0;
	assign sq_side_s[0] = div_side_s[vac_pkg::DIV_N];

	for (genvar j = 0; j < vac_pkg::SQRT_N; j++) begin : g_sqrt
		localparam int B = vac_pkg::SQRT_N - 1 - j;
		logic [57:0] trial;
		logic        take;
		assign trial = (58'(sq_root_s[j]) << (B + 1)) + (58'd1 << (2 * B));
		assign take  = trial <= sq_rem_s[j];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[j+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[j+1] <= sq_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem_s[j+1]  <= take ? sq_rem_s[j] - trial : sq_rem_s[j];
				sq_root_s[j+1] <= sq_root_s[j] | (take ? (vac_pkg::SQRT_N)'(1) << B : '0);
				sq_side_s[j+1] <= sq_side_s[j];
			end
		end
	end

	// output register and skid
	logic               fin_v;
	vac_pkg::result_t   fin;
	logic signed [31:0] mag;
	logic               result_valid_q;
	vac_pkg::result_t   result_q, skid_q;

	assign fin_v          = sq_v_s[vac_pkg::SQRT_N];
	assign mag            = signed'(32'(sq_root_s[vac_pkg::SQRT_N]));
	assign fin.degenerate = sq_side_s[vac_pkg::SQRT_N].degen;
	assign fin.cosine     = sq_side_s[vac_pkg::SQRT_N].degen ? vac_pkg::MARKER_FOUR
		: (sq_side_s[vac_pkg::SQRT_N].neg ? -mag : mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			skid_valid_q   <= 1'b0;
		end else if (skid_valid_q) begin
			if (!result_stall) begin
				skid_valid_q <= 1'b0;
			end
		end else if (fin_v) begin
			if (!result_valid_q || !result_stall) begin
				result_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (!result_stall) begin
				result_q <= skid_q;
			end
		end else if (fin_v) begin
			if (!result_valid_q || !result_stall) begin
				result_q <= fin;
			end else begin
				skid_q <= fin;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("input stalled with no result held");

	a_degen_marker: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.degenerate |-> result.cosine == vac_pkg::MARKER_FOUR)
		else $error("degenerate result without marker");

	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.degenerate |->
		(result.cosine <= 32'sd268435456) && (result.cosine >= -32'sd268435456))
		else $error("cosine out of range");

endmodule
